// ----- src/fccl_pkg.sv -----
// Package for the FAT cluster chain lookup unit.
// Holds the stream widths, register indexes, command and table format codes,
// and the end-of-chain constants shared by the top level and the entry decoder.
package fccl_pkg;

  // Default window geometry
  localparam int unsigned WINDOW_SECTORS_DEF = 4;
  localparam int unsigned SECTOR_BYTES_DEF   = 512;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 104;

  // Field widths
  localparam int unsigned CLUSTER_W = 28;
  localparam int unsigned OFFSET_W  = 11;
  localparam int unsigned FOFF_W    = 30;  // FAT byte offset of an entry

  // Command codes carried in the input tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Table formats
  localparam logic [1:0] FAT_12 = 2'd0;
  localparam logic [1:0] FAT_16 = 2'd1;
  localparam logic [1:0] FAT_32 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FAT_TYPE    = 2'd0;
  localparam logic [1:0] REG_RSVD_SECT   = 2'd1;
  localparam logic [1:0] REG_SECT_PER_CL = 2'd2;
  localparam logic [1:0] REG_DATA_START  = 2'd3;

  // Entry masks and end-of-chain thresholds
  localparam logic [31:0] FAT12_MASK   = 32'h0000_0FFF;
  localparam logic [31:0] FAT12_EOC    = 32'h0000_0FF8;
  localparam logic [31:0] FAT12_EXT    = 32'hFFFF_F000;
  localparam logic [31:0] FAT16_EOC    = 32'h0000_FFF8;
  localparam logic [31:0] FAT16_EXT    = 32'hFFFF_0000;
  localparam logic [31:0] FAT32_MASK   = 32'h0FFF_FFFF;
  localparam logic [31:0] FAT32_EOC    = 32'h0FFF_FFF8;
  localparam logic [31:0] FAT32_EXT    = 32'hF000_0000;
  localparam logic [31:0] CHAIN_END    = 32'hFFFF_FFF8;

endpackage

// ----- src/fccl_entry_dec.sv -----
// Decoder for one raw FAT entry: picks the FAT12 nibble half, masks FAT32
// entries and extends end-of-chain values upward. Depends on fccl_pkg.
module fccl_entry_dec
  import fccl_pkg::*;
(
  input  logic [1:0]  fat_type_i,
  input  logic        cluster_odd_i,
  input  logic [31:0] raw_i,
  output logic [31:0] next_cluster_o,
  output logic        end_of_chain_o
);

  logic [31:0] next;

  always_comb begin
    next = 32'd0;
    case (fat_type_i)
      FAT_12: begin
        next = cluster_odd_i ? {20'd0, raw_i[15:4]} : (raw_i & FAT12_MASK);
        if (next >= FAT12_EOC) next = next | FAT12_EXT;
      end
      FAT_16: begin
        next = {16'd0, raw_i[15:0]};
        if (next >= FAT16_EOC) next = next | FAT16_EXT;
      end
      default: begin
        // unused format code behaves as FAT32
        next = raw_i & FAT32_MASK;
        if (next >= FAT32_EOC) next = next | FAT32_EXT;
      end
    endcase
  end

  assign next_cluster_o = next;
  assign end_of_chain_o = (next >= CHAIN_END);

endmodule

// ----- src/fat_cluster_chain_lookup_unit.sv -----
// Top level of the FAT cluster chain lookup unit: window memory, sequencer,
// shift-add cluster LBA multiplier and output register.
// Depends on fccl_pkg and fccl_entry_dec.
// Usage:
//   Input stream (s_axis_*): tuser is the command. A write item stores one
//   byte of the FAT window at cache_offset (offsets past the window are
//   dropped). A lookup item yields one result item on the output stream
//   (m_axis_*): tuser is the hit flag, tdata carries the FAT read LBA
//   (miss), the decoded successor (hit) and the cluster LBA. A lookup
//   runs 8 shift-add steps for the cluster LBA and one window check; on a
//   hit it then reads each entry byte through the single read port of the
//   window memory (two bytes for FAT12/FAT16, four for FAT32) with a read
//   step and a capture step; last it loads the output register.
//   s_axis_tready is low meanwhile. A finished result sits in the output
//   register; a new item is accepted while it waits, but the next lookup
//   holds in its final step until the receiver takes the previous result.
//   Configuration writes are taken on any cycle (cfg_ready_o is high) and
//   must only be issued while the block is idle. Reset empties the window
//   and loads the register defaults; window bytes are undefined until written.
module fat_cluster_chain_lookup_unit
  import fccl_pkg::*;
#(
  parameter int unsigned WINDOW_SECTORS = WINDOW_SECTORS_DEF,
  parameter int unsigned SECTOR_BYTES   = SECTOR_BYTES_DEF  // power of two
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: cache_offset[10:0], cache_byte[18:11], cluster[46:19], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command
  input  logic                   s_axis_tuser,
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: fat_read_lba[31:0], next_cluster[63:32], end_of_chain[64],
  //        cluster_lba[96:65], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: hit
  output logic                   m_axis_tuser,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int unsigned WINDOW_BYTES = WINDOW_SECTORS * SECTOR_BYTES;
  localparam int unsigned AW           = $clog2(WINDOW_BYTES);
  localparam int unsigned LOC_W        = AW + 1;
  localparam int unsigned LOG_SB       = $clog2(SECTOR_BYTES);
  localparam int unsigned SECT_W       = FOFF_W - LOG_SB;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_RD,
    S_CAP,
    S_DONE
  } state_e;

  // configuration registers
  logic [1:0]  fat_type_q;
  logic [15:0] rsvd_sect_q;
  logic [7:0]  sect_per_cl_q;
  logic [31:0] data_start_q;

  // sequencer and working registers
  state_e             state_q;
  logic [2:0]         mul_cnt_q;
  logic [7:0]         mult_q;
  logic [31:0]        mcand_q;
  logic [31:0]        acc_q;
  logic [FOFF_W-1:0]  fat_off_q;
  logic               clus_odd_q;
  logic [SECT_W-1:0]  base_q;
  logic               win_valid_q;
  logic               hit_q;
  logic [31:0]        read_lba_q;
  logic [LOC_W-1:0]   local_q;
  logic [1:0]         byte_idx_q;
  logic               in_range_q;
  logic [31:0]        raw_q;

  // output register
  logic                   out_valid_q;
  logic                   out_user_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // window memory
  logic [7:0]    mem [WINDOW_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  // input fields
  logic [OFFSET_W-1:0]  in_offset;
  logic [7:0]           in_byte;
  logic [CLUSTER_W-1:0] in_cluster;
  logic                 in_accept;

  logic [FOFF_W-1:0]  cl_x3;
  logic [FOFF_W-1:0]  fat_off_d;
  logic [SECT_W-1:0]  sector;
  logic [SECT_W:0]    base_end;
  logic               miss;
  logic [SECT_W-1:0]  sect_delta;
  logic [FOFF_W-1:0]  local_full;
  logic [LOC_W-1:0]   rd_pos;
  logic [1:0]         last_idx;
  logic               out_free;
  logic               out_load;
  logic [31:0]        dec_next;
  logic               dec_eoc;

  assign in_offset  = s_axis_tdata[10:0];
  assign in_byte    = s_axis_tdata[18:11];
  assign in_cluster = s_axis_tdata[46:19];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // FAT byte offset of the entry
  assign cl_x3 = FOFF_W'({2'd0, in_cluster}) + FOFF_W'({1'b0, in_cluster, 1'b0});
  always_comb begin
    case (fat_type_q)
      FAT_12:  fat_off_d = cl_x3 >> 1;
      FAT_16:  fat_off_d = FOFF_W'({1'b0, in_cluster, 1'b0});
      default: fat_off_d = {in_cluster, 2'b00};
    endcase
  end

  // window check
  assign sector     = fat_off_q[FOFF_W-1:LOG_SB];
  assign base_end   = {1'b0, base_q} + (SECT_W+1)'(WINDOW_SECTORS);
  assign miss       = !win_valid_q || (sector < base_q) || ({1'b0, sector} >= base_end);
  assign sect_delta = sector - base_q;
  assign local_full = {sect_delta, fat_off_q[LOG_SB-1:0]};
  assign rd_pos     = local_q + LOC_W'(byte_idx_q);
  assign last_idx   = ((fat_type_q == FAT_12) || (fat_type_q == FAT_16)) ? 2'd1 : 2'd3;

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_DONE) && out_free;

  // memory ports
  assign mem_we    = in_accept && (s_axis_tuser == CMD_WRITE) &&
                     (32'(in_offset) < 32'(WINDOW_BYTES));
  assign mem_waddr = AW'(32'(in_offset));
  assign mem_raddr = AW'(rd_pos);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_byte;
    end
    rdata_q <= mem[mem_raddr];
  end

  fccl_entry_dec u_dec (
    .fat_type_i     (fat_type_q),
    .cluster_odd_i  (clus_odd_q),
    .raw_i          (raw_q),
    .next_cluster_o (dec_next),
    .end_of_chain_o (dec_eoc)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_type_q    <= FAT_12;
      rsvd_sect_q   <= 16'd1;
      sect_per_cl_q <= 8'd1;
      data_start_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FAT_TYPE:    fat_type_q    <= cfg_data_i[1:0];
        REG_RSVD_SECT:   rsvd_sect_q   <= cfg_data_i[15:0];
        REG_SECT_PER_CL: sect_per_cl_q <= cfg_data_i[7:0];
        REG_DATA_START:  data_start_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_valid_q <= 1'b0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      mul_cnt_q   <= 3'd0;
      byte_idx_q  <= 2'd0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept && (s_axis_tuser == CMD_LOOKUP)) begin
            fat_off_q  <= fat_off_d;
            clus_odd_q <= in_cluster[0];
            mcand_q    <= {4'd0, in_cluster} - 32'd2;
            mult_q     <= sect_per_cl_q;
            acc_q      <= data_start_q;
            mul_cnt_q  <= 3'd0;
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          // one shift-add step per cycle
          if (mult_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q   <= mcand_q << 1;
          mult_q    <= mult_q >> 1;
          mul_cnt_q <= mul_cnt_q + 3'd1;
          if (mul_cnt_q == 3'd7) state_q <= S_CHECK;
        end
        S_CHECK: begin
          byte_idx_q <= 2'd0;
          raw_q      <= 32'd0;
          local_q    <= LOC_W'(local_full);
          if (miss) begin
            base_q      <= sector;
            win_valid_q <= 1'b1;
            hit_q       <= 1'b0;
            read_lba_q  <= 32'(rsvd_sect_q) + 32'(sector);
            state_q     <= S_DONE;
          end else begin
            hit_q      <= 1'b1;
            read_lba_q <= 32'd0;
            state_q    <= S_RD;
          end
        end
        S_RD: begin
          // memory data lands in rdata_q at this edge
          in_range_q <= (32'(rd_pos) < 32'(WINDOW_BYTES));
          state_q    <= S_CAP;
        end
        S_CAP: begin
          raw_q[8*byte_idx_q +: 8] <= in_range_q ? rdata_q : 8'd0;
          byte_idx_q <= byte_idx_q + 2'd1;
          state_q    <= (byte_idx_q == last_idx) ? S_DONE : S_RD;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_user_q  <= hit_q;
            out_data_q  <= {7'd0, acc_q,
                            hit_q ? dec_eoc : 1'b0,
                            hit_q ? dec_next : 32'd0,
                            read_lba_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

endmodule
